FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every rising edge of clk, during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/lcc_pkg.sv
// ---------------------------------------------------------------------------
// lcc_pkg
// Constants and widths for the lattice coefficient compression datapath.
// ---------------------------------------------------------------------------
package lcc_pkg;

  // Modulus and rounding offset.
  localparam int unsigned KYBER_Q = 3329;
  localparam int unsigned HALF_Q  = KYBER_Q / 2;

  // Legal range and reset value of the compressed bit count D.
  localparam int unsigned D_MIN   = 1;
  localparam int unsigned D_MAX   = 11;
  localparam int unsigned D_RESET = 10;

  // Field widths.
  localparam int unsigned COEFF_W = 13;
  localparam int unsigned DBITS_W = 4;
  localparam int unsigned QUOT_W  = 12;
  localparam int unsigned COMP_W  = 11;
  localparam int unsigned REM_W   = 12;

  // Internal widths: the scaled product a * 2^D needs COEFF_W + D_MAX bits.
  localparam int unsigned PROD_W  = COEFF_W + D_MAX;
  localparam int unsigned QMAG_W  = 13;
  localparam int unsigned QSGN_W  = QMAG_W + 1;
  localparam int unsigned WIDE_W  = PROD_W + 1;

  // Reciprocal of q: floor(n * RECIP_M / 2^RECIP_SHIFT) equals floor(n / q)
  // for every n below 2^24, which covers |a * 2^D| + q/2.
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_M = 25'd20642679;
  localparam int unsigned MUL_W       = PROD_W + RECIP_W;

  typedef logic [DBITS_W-1:0] dbits_t;

endpackage

FILE: hdl/lattice_coefficient_compress.sv
// ---------------------------------------------------------------------------
// lattice_coefficient_compress
// Scales one signed coefficient modulo 3329 by 2^D and divides by q.
// ---------------------------------------------------------------------------
// The block takes one coefficient word per clock cycle and never asserts
// busy, so start may be held high for a whole stream. Each word goes through
// an input register and a result register. Its result is shown when it
// leaves the result register, marked by a one-cycle out_valid strobe. The
// receiver cannot stall the block and must take every result word in the
// cycle it is shown. One word per cycle is sustained because all the
// arithmetic for a word, including the single reciprocal multiplier, sits
// between the two registers with nothing iterative. The bit count D is
// written through cfg_we and cfg_d_bits and should only be changed while no
// word is in flight; a value of 0 acts as D = 1 and values above 11 act as
// D = 11.
module lattice_coefficient_compress
  import lcc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Input word.
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COEFF_W-1:0] in_coeff,
  // Configuration.
  input  logic                      cfg_we,
  input  logic [DBITS_W-1:0]        cfg_d_bits,
  // Result word.
  output logic                      out_valid,
  output logic signed [QUOT_W-1:0]  out_signed_quotient,
  output logic [COMP_W-1:0]         out_compressed,
  output logic signed [REM_W-1:0]   out_scaled_remainder
);

`include "assert_macros.svh"

  // The pipeline never holds off new words.
  assign busy = 1'b0;

  // Configuration register.
  dbits_t d_bits_r;
  dbits_t d_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_bits_r <= DBITS_W'(D_RESET);
    end else if (cfg_we) begin
      d_bits_r <= cfg_d_bits;
    end
  end

  // Out-of-range codes are clamped onto the legal range of D.
  always_comb begin
    d_eff = d_bits_r;
    if (d_bits_r < DBITS_W'(D_MIN)) begin
      d_eff = DBITS_W'(D_MIN);
    end else if (d_bits_r > DBITS_W'(D_MAX)) begin
      d_eff = DBITS_W'(D_MAX);
    end
  end

  // Input register.
  logic               in_valid_r;
  logic [COEFF_W-1:0] coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      coeff_r <= in_coeff;
    end
  end

  // Datapath. The product a * 2^D is rounded to the nearest multiple of q.
  // Since q is odd no exact half occurs, so rounding the magnitude and
  // restoring the sign gives the symmetric rounding directly.
  logic [PROD_W-1:0] prod;
  logic              prod_neg;
  logic [PROD_W-1:0] prod_mag;
  logic [PROD_W-1:0] round_in;
  logic [MUL_W-1:0]  recip_prod;
  logic [QMAG_W-1:0] quot_mag;
  logic [QSGN_W-1:0] quot;
  logic [WIDE_W-1:0] quot_ext;
  logic [WIDE_W-1:0] quot_times_q;
  logic [WIDE_W-1:0] rem_wide;
  logic [QUOT_W-1:0] dmask_wide;
  logic [COMP_W-1:0] dmask;

  always_comb begin
    prod       = {{(PROD_W-COEFF_W){coeff_r[COEFF_W-1]}}, coeff_r} << d_eff;
    prod_neg   = prod[PROD_W-1];
    prod_mag   = prod_neg ? (PROD_W'(0) - prod) : prod;
    round_in   = prod_mag + PROD_W'(HALF_Q);
    recip_prod = MUL_W'(round_in) * MUL_W'(RECIP_M);
    quot_mag   = recip_prod[RECIP_SHIFT +: QMAG_W];
    quot       = prod_neg ? (QSGN_W'(0) - {1'b0, quot_mag}) : {1'b0, quot_mag};

    // quot * 3329 as shift-and-add, since 3329 = 2^11 + 2^10 + 2^8 + 1.
    quot_ext     = {{(WIDE_W-QSGN_W){quot[QSGN_W-1]}}, quot};
    quot_times_q = (quot_ext << 11) + (quot_ext << 10) + (quot_ext << 8) + quot_ext;
    rem_wide     = {prod[PROD_W-1], prod} - quot_times_q;

    // Adding q to a negative coefficient shifts the quotient by exactly 2^D,
    // which the D-bit mask removes, so the compressed value is the low D
    // bits of the signed quotient.
    dmask_wide = (QUOT_W'(1) << d_eff) - QUOT_W'(1);
    dmask      = dmask_wide[COMP_W-1:0];
  end

  // Result register.
  logic              out_valid_r;
  logic [QUOT_W-1:0] quot_r;
  logic [COMP_W-1:0] comp_r;
  logic [REM_W-1:0]  rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      quot_r <= quot[QUOT_W-1:0];
      comp_r <= quot[COMP_W-1:0] & dmask;
      rem_r  <= rem_wide[REM_W-1:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_signed_quotient  = quot_r;
  assign out_compressed       = comp_r;
  assign out_scaled_remainder = rem_r;

  // Every accepted word yields a result strobe from the result register.
  `ASSERT_CLK(a_result_follows_start, out_valid_r == $past(start, 2) || !$past(rst_n, 2), "result strobe does not match accepted word")
  // The rounding leaves a remainder of at most half of q in magnitude.
  `ASSERT_CLK(a_remainder_range, in_valid_r |-> ($signed(rem_wide) <= $signed(WIDE_W'(HALF_Q)) && $signed(rem_wide) >= -$signed(WIDE_W'(HALF_Q))), "remainder outside half of q")
  // The compressed value never has bits at or above D.
  `ASSERT_CLK(a_compressed_masked, out_valid_r |-> (out_compressed & ~dmask) == '0, "compressed value exceeds D bits")
  // Nothing is strobed out in the cycle after reset.
  `ASSERT_ALWAYS(a_no_result_after_reset, !$past(rst_n) |-> !out_valid_r, "result strobe right after reset")

endmodule

FILE: tb/sv/tb_lattice_coefficient_compress.sv
// ---------------------------------------------------------------------------
// tb_lattice_coefficient_compress
// Self-checking bench for the coefficient scale-and-compress datapath.
// ---------------------------------------------------------------------------
// Coefficient words are sent through the start/busy handshake and every
// result word is compared with a prediction made when its coefficient was
// accepted. A short table of directed words comes first. Some rows carry
// hand-computed results and the rest are predicted. After the table come
// phases of random words, each under its own setting of D, with register
// values drawn from the whole 4-bit range.
// ---------------------------------------------------------------------------
module tb_lattice_coefficient_compress
  import lcc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MODULUS  = KYBER_Q;
  localparam int HALF_MOD = HALF_Q;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED = 24;
  localparam int N_PHASES = 20;
  localparam int WORDS_PER_PHASE = 50;
  localparam int IDLE_PCT = 36;

  // One result word, held as raw bits at the port widths.
  typedef struct packed {
    logic [QUOT_W-1:0] quotient;
    logic [COMP_W-1:0] comp;
    logic [REM_W-1:0]  rem;
  } compress_word_t;

  // One row of the directed table. When wr_d is set, D is rewritten before
  // the word is sent. When hand is set, want is the result for the row.
  typedef struct packed {
    logic               wr_d;
    logic [DBITS_W-1:0] d;
    logic [COEFF_W-1:0] coeff;
    logic               hand;
    compress_word_t     want;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COEFF_W-1:0] in_coeff = '0;
  logic                      cfg_we = 1'b0;
  logic [DBITS_W-1:0]        cfg_d_bits = '0;
  logic                      out_valid;
  logic signed [QUOT_W-1:0]  out_signed_quotient;
  logic [COMP_W-1:0]         out_compressed;
  logic signed [REM_W-1:0]   out_scaled_remainder;

  // Results still owed by the block, oldest first.
  compress_word_t owed_words[$];

  // The bench's copy of the D register. It starts at the reset value.
  logic [DBITS_W-1:0] d_now = DBITS_W'(D_RESET);
  logic [15:0]        d_seen = '0;
  int                 errors = 0;
  int                 words_sent = 0;
  int                 words_checked = 0;
  int                 wild_words = 0;
  int                 cycles = 0;
  int                 idle_pct = IDLE_PCT;

  // Directed words. Hand-computed results cover the reset value of D, the
  // largest and smallest coefficients at D = 11, the largest remainder at
  // D = 1, and the clamping of register values 0 and 15.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 4'd0,  13'sd0,     1'b1, '{12'sd0,     11'd0,    12'sd0}},
    '{1'b0, 4'd0,  13'sd1,     1'b1, '{12'sd0,     11'd0,    12'sd1024}},
    // At D = 10, -1 compresses to 1024, which the mask folds back to 0.
    '{1'b0, 4'd0,  -13'sd1,    1'b1, '{12'sd0,     11'd0,    -12'sd1024}},
    '{1'b0, 4'd0,  13'sd3328,  1'b0, '0},
    '{1'b0, 4'd0,  -13'sd1664, 1'b0, '0},
    '{1'b1, 4'd11, 13'sd3328,  1'b1, '{12'sd2047,  11'd2047, 12'sd1281}},
    '{1'b0, 4'd11, -13'sd1664, 1'b1, '{-12'sd1024, 11'd1024, 12'sd1024}},
    '{1'b0, 4'd11, 13'sd1664,  1'b0, '0},
    '{1'b0, 4'd11, 13'sd1665,  1'b0, '0},
    '{1'b1, 4'd1,  13'sd832,   1'b1, '{12'sd0,     11'd0,    12'sd1664}},
    '{1'b0, 4'd1,  13'sd833,   1'b1, '{12'sd1,     11'd1,    -12'sd1663}},
    '{1'b0, 4'd1,  -13'sd832,  1'b0, '0},
    // A register value of 0 must behave as D = 1.
    '{1'b1, 4'd0,  13'sd833,   1'b1, '{12'sd1,     11'd1,    -12'sd1663}},
    '{1'b0, 4'd0,  13'sd3328,  1'b0, '0},
    // A register value of 15 must behave as D = 11.
    '{1'b1, 4'd15, 13'sd3328,  1'b1, '{12'sd2047,  11'd2047, 12'sd1281}},
    // Coefficients outside the nominal range, including ones that stay
    // negative after q is added.
    '{1'b0, 4'd15, 13'sd4095,  1'b0, '0},
    '{1'b0, 4'd15, -13'sd4096, 1'b0, '0},
    '{1'b0, 4'd15, -13'sd3330, 1'b0, '0},
    '{1'b0, 4'd15, -13'sd3329, 1'b0, '0},
    '{1'b1, 4'd12, -13'sd1,    1'b0, '0},
    '{1'b1, 4'd13, 13'sd1000,  1'b0, '0},
    '{1'b1, 4'd14, -13'sd1000, 1'b0, '0},
    '{1'b1, 4'd5,  13'sd104,   1'b0, '0},
    '{1'b1, 4'd10, 13'sd4095,  1'b0, '0}
  };

  lattice_coefficient_compress dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_coeff             (in_coeff),
    .cfg_we               (cfg_we),
    .cfg_d_bits           (cfg_d_bits),
    .out_valid            (out_valid),
    .out_signed_quotient  (out_signed_quotient),
    .out_compressed       (out_compressed),
    .out_scaled_remainder (out_scaled_remainder)
  );

  always #5 clk = ~clk;

  // Division by q with rounding to nearest, symmetric about zero. Since q is
  // odd, the exact quotient is never a half-integer, so there are no ties.
  function automatic int round_over_q(input int v);
    if (v >= 0) begin
      return (v + HALF_MOD) / MODULUS;
    end
    return -((-v + HALF_MOD) / MODULUS);
  endfunction

  // Expected result word for one coefficient under a given register value.
  function automatic compress_word_t compress_coeff(input logic [COEFF_W-1:0] coeff,
                                                    input logic [DBITS_W-1:0] d_reg);
    int a;
    int d;
    int prod;
    int quot;
    int lifted;
    int comp_full;
    compress_word_t w;
    a = int'($signed(coeff));
    // Register values outside 1..11 clamp to the nearest legal D.
    d = int'(d_reg);
    if (d < int'(D_MIN)) begin
      d = D_MIN;
    end
    if (d > int'(D_MAX)) begin
      d = D_MAX;
    end
    prod = a * (1 << d);
    quot = round_over_q(prod);
    // Negative coefficients are lifted by q before compression. A few very
    // negative out-of-range ones stay negative, and their rounded quotient
    // is masked as two's complement.
    lifted = (a < 0) ? a + MODULUS : a;
    comp_full = round_over_q(lifted * (1 << d));
    w.quotient = quot[QUOT_W-1:0];
    w.comp     = comp_full[COMP_W-1:0] & COMP_W'((1 << d) - 1);
    w.rem      = REM_W'(prod - quot * MODULUS);
    return w;
  endfunction

  // Sends one coefficient word. Before it, the sender may idle at random,
  // with start low. Start is dropped at most once and raised at most once per
  // time step. The expectation is queued at the edge that accepts the word.
  task automatic send_word(input logic [COEFF_W-1:0] coeff, input bit hand,
                           input compress_word_t want);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < idle_pct);
    end
    start    <= 1'b1;
    in_coeff <= coeff;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    owed_words.push_back(hand ? want : compress_coeff(coeff, d_now));
    words_sent++;
    if ($signed(coeff) < -HALF_MOD || $signed(coeff) > MODULUS - 1) begin
      wild_words++;
    end
  endtask

  // Stops sending and waits until every owed result word has come back.
  // Every word yields exactly one result, so an empty queue means nothing
  // is left in flight.
  task automatic drain;
    start <= 1'b0;
    while (owed_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the D register. The caller has drained the block beforehand.
  task automatic write_d(input logic [DBITS_W-1:0] value);
    cfg_we     <= 1'b1;
    cfg_d_bits <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    d_now  = value;
    d_seen[value] = 1'b1;
  endtask

  // The results checker. The receiver cannot stall, so each strobe is
  // taken at the edge that ends its cycle.
  always @(posedge clk) begin
    compress_word_t want;
    if (rst_n && out_valid) begin
      if (owed_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word q=%0d c=%0d r=%0d", $time,
                 out_signed_quotient, out_compressed, out_scaled_remainder);
      end else begin
        want = owed_words.pop_front();
        words_checked++;
        if (want.quotient !== out_signed_quotient) begin
          errors++;
          $display("%0t: signed_quotient expected %0d, got %0d", $time,
                   $signed(want.quotient), out_signed_quotient);
        end
        if (want.comp !== out_compressed) begin
          errors++;
          $display("%0t: compressed expected %0d, got %0d", $time,
                   want.comp, out_compressed);
        end
        if (want.rem !== out_scaled_remainder) begin
          errors++;
          $display("%0t: scaled_remainder expected %0d, got %0d", $time,
                   $signed(want.rem), out_scaled_remainder);
        end
      end
    end
  end

  // Watchdog. A lost result word leaves the drain waiting forever, so it
  // ends here as well.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words still owed", cycles,
               owed_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [COEFF_W-1:0] coeff;
    logic [DBITS_W-1:0] d_next;
    int                 pick;
    int                 nominal;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed table. The first rows run on the reset value of D.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].wr_d) begin
        drain();
        write_d(directed_rows[i].d);
      end
      send_word(directed_rows[i].coeff, directed_rows[i].hand, directed_rows[i].want);
    end

    // Random phases. The first two pin D at its extremes and later ones
    // pick any register value, clamped ones included. Phases 4 to 6 send
    // back to back, with no idle cycles.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      if (phase == 0) begin
        d_next = DBITS_W'(D_MIN);
      end else if (phase == 1) begin
        d_next = DBITS_W'(D_MAX);
      end else begin
        d_next = DBITS_W'($urandom_range(15));
      end
      drain();
      write_d(d_next);
      idle_pct = (phase >= 4 && phase <= 6) ? 0 : IDLE_PCT;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // In the middle of one phase, the sender holds off until every
        // owed result word has come back, then continues with no write.
        if (phase == 10 && n == WORDS_PER_PHASE / 2) begin
          drain();
        end
        pick = $urandom_range(9);
        if (pick < 7) begin
          // Nominal range, -q/2 .. q-1.
          nominal = $urandom_range(MODULUS - 1 + HALF_MOD) - HALF_MOD;
          coeff   = nominal[COEFF_W-1:0];
        end else if (pick < 9) begin
          // Any 13-bit pattern, so that every input bit takes both values.
          coeff = COEFF_W'($urandom);
        end else begin
          // Rounding edges and range limits.
          case ($urandom_range(7))
            0:       coeff = '0;
            1:       coeff = COEFF_W'(HALF_MOD);
            2:       coeff = COEFF_W'(HALF_MOD + 1);
            3:       coeff = COEFF_W'(MODULUS - 1);
            4:       coeff = COEFF_W'(-HALF_MOD);
            5:       coeff = COEFF_W'(-MODULUS - 1);
            6:       coeff = {1'b1, {(COEFF_W-1){1'b0}}};
            default: coeff = {1'b0, {(COEFF_W-1){1'b1}}};
          endcase
        end
        send_word(coeff, 1'b0, '0);
      end
    end

    // The result path has two register stages, so the wait after the drain is
    // long enough to catch a stray strobe.
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d coefficient words (%0d outside the nominal range), checked %0d results.",
             words_sent, wild_words, words_checked);
    $display("D register values written: %b (bit n set for value n), %0d field errors.",
             d_seen, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
